// ===== design/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants, codes and controller/datapath types for the line plotter.
// ----------------------------------------------------------------------------
package lfp_pkg;

	localparam int MAX_WIDTH_DEF   = 128;
	localparam int MAX_HEIGHT_DEF  = 64;
	localparam int STORE_DEPTH_DEF = 1024;
	localparam int COORD_BITS_DEF  = 10;

	localparam int PAGE_ROWS  = 8;
	localparam int PAGE_SHIFT = 3;

	localparam int FUNC_BITS       = 2;
	localparam int PEN_BITS        = 2;
	localparam int READ_INDEX_BITS = 10;
	localparam int DATA_BITS       = 8;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 8;
	localparam int WIDTH_REG_BITS  = 8;
	localparam int HEIGHT_REG_BITS = 7;

	localparam logic [FUNC_BITS-1:0] FN_LINE  = 2'd0;
	localparam logic [FUNC_BITS-1:0] FN_CLEAR = 2'd1;
	localparam logic [FUNC_BITS-1:0] FN_READ  = 2'd2;

	localparam logic [PEN_BITS-1:0] PEN_CLEAR  = 2'd0;
	localparam logic [PEN_BITS-1:0] PEN_SET    = 2'd1;
	localparam logic [PEN_BITS-1:0] PEN_INVERT = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [WIDTH_REG_BITS-1:0]  SCREEN_WIDTH_RST  = 8'd128;
	localparam logic [HEIGHT_REG_BITS-1:0] SCREEN_HEIGHT_RST = 7'd64;

	typedef struct packed {
		logic load;
		logic init_step;
		logic line_rd;
		logic line_wr;
		logic clr_step;
		logic rd_issue;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic init_last;
		logic cnt_zero;
		logic clr_last;
	} sts_t;

endpackage

// ===== design/lfp_ram.sv =====
// ----------------------------------------------------------------------------
// lfp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/lfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfp_ctrl
// Sequencer: store clearing pass, command dispatch, line/clear/read walks and
// the result register handshake.
// ----------------------------------------------------------------------------
module lfp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [lfp_pkg::FUNC_BITS-1:0]  func,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output lfp_pkg::ctl_t                  ctl,
	input  lfp_pkg::sts_t                  sts
);
	import lfp_pkg::*;

	typedef enum logic [6:0] {
		S_INIT    = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_LINE_RD = 7'b0000100,
		S_LINE_WR = 7'b0001000,
		S_CLEAR   = 7'b0010000,
		S_READ    = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				ctl.init_step = 1'b1;
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					case (func)
						FN_LINE:  state_d = S_LINE_RD;
						FN_CLEAR: state_d = S_CLEAR;
						FN_READ:  state_d = S_READ;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_LINE_RD: begin
				ctl.line_rd = 1'b1;
				state_d     = S_LINE_WR;
			end
			S_LINE_WR: begin
				ctl.line_wr = 1'b1;
				state_d     = sts.cnt_zero ? S_DONE : S_LINE_RD;
			end
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_READ: begin
				ctl.rd_issue = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted while busy");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(ctl.init_step || ctl.clr_step || ctl.line_wr))
		else $error("store write while idle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_line_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINE_WR) |=> (state_q == S_LINE_RD || state_q == S_DONE))
		else $error("line walk left its loop");

endmodule

// ===== design/lfp_dp.sv =====
// ----------------------------------------------------------------------------
// lfp_dp
// Datapath: configuration registers, Bresenham stepper, pixel address unit,
// sweep counter, frame store and result registers.
// ----------------------------------------------------------------------------
module lfp_dp #(
	parameter int MAX_WIDTH   = lfp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = lfp_pkg::MAX_HEIGHT_DEF,
	parameter int STORE_DEPTH = lfp_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS  = lfp_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lfp_pkg::ctl_t                        ctl,
	output lfp_pkg::sts_t                        sts,
	input  logic                                 cfg_valid,
	input  logic [lfp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lfp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic [lfp_pkg::FUNC_BITS-1:0]        func,
	input  logic signed [COORD_BITS-1:0]         x_start,
	input  logic signed [COORD_BITS-1:0]         y_start,
	input  logic signed [COORD_BITS-1:0]         x_end,
	input  logic signed [COORD_BITS-1:0]         y_end,
	input  logic [lfp_pkg::PEN_BITS-1:0]         pen_mode,
	input  logic [lfp_pkg::READ_INDEX_BITS-1:0]  read_index,
	output logic [lfp_pkg::DATA_BITS-1:0]        read_data,
	output logic                                 index_error
);
	import lfp_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int PB = $clog2(MAX_HEIGHT / PAGE_ROWS + 1);
	localparam int NW = WB + PB;
	localparam int IW = WB + PB + 1;
	localparam int XW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 2;
	localparam int LW = WB + PB + CW + COORD_BITS + READ_INDEX_BITS;

	// configuration
	logic [WIDTH_REG_BITS-1:0]  sw_q;
	logic [HEIGHT_REG_BITS-1:0] sh_q;
	logic [WB-1:0]              w_eff;
	logic [7:0]                 h_min;
	logic [PB-1:0]              pages;
	logic [NW-1:0]              prod;
	logic [CW-1:0]              n_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SCREEN_WIDTH_RST;
			sh_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  sw_q <= cfg_data;
				REG_SCREEN_HEIGHT: sh_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (9'(sw_q) > 9'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
		else                          w_eff = WB'(sw_q);
		h_min   = (8'(sh_q) > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : 8'(sh_q);
		pages   = PB'(h_min >> PAGE_SHIFT);
		prod    = NW'(w_eff) * NW'(pages);
		n_bytes = (LW'(prod) > LW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : CW'(prod);
	end

	// command registers
	logic [FUNC_BITS-1:0]       func_q;
	logic [PEN_BITS-1:0]        mode_q;
	logic [READ_INDEX_BITS-1:0] ridx_q;
	logic signed [XW-1:0]       x_q, y_q;
	logic [COORD_BITS-1:0]      dmaj_q, dmin_q, cnt_q;
	logic signed [EW-1:0]       err_q;
	logic                       sx_neg_q, sy_neg_q, xmaj_q;
	logic [AW-1:0]              addr_q;

	// line setup
	logic signed [XW-1:0]  x0e, y0e, x1e, y1e, dx, dy;
	logic [COORD_BITS-1:0] adx, ady;
	logic                  xmaj_n;

	always_comb begin
		x0e    = XW'(x_start);
		y0e    = XW'(y_start);
		x1e    = XW'(x_end);
		y1e    = XW'(y_end);
		dx     = x1e - x0e;
		dy     = y1e - y0e;
		adx    = dx[XW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady    = dy[XW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		xmaj_n = (adx >= ady);
	end

	// Bresenham step
	logic signed [EW-1:0] e1, err_n;
	logic                 neg, step_x, step_y;
	logic signed [XW-1:0] x_n, y_n;

	always_comb begin
		e1     = err_q - EW'({1'b0, dmin_q});
		neg    = e1[EW-1];
		err_n  = neg ? (e1 + EW'({1'b0, dmaj_q})) : e1;
		step_x = xmaj_q || neg;
		step_y = !xmaj_q || neg;
		x_n    = x_q;
		y_n    = y_q;
		if (step_x) x_n = sx_neg_q ? (x_q - XW'(1)) : (x_q + XW'(1));
		if (step_y) y_n = sy_neg_q ? (y_q - XW'(1)) : (y_q + XW'(1));
	end

	// pixel address
	logic [IW-1:0] idx;
	logic          vis;

	always_comb begin
		idx = IW'(x_q[XW-2:0]) + IW'(y_q[XW-2:PAGE_SHIFT]) * IW'(w_eff);
		vis = !x_q[XW-1] && !y_q[XW-1]
			&& (LW'(x_q[XW-2:0]) < LW'(w_eff))
			&& (LW'(y_q[XW-2:PAGE_SHIFT]) < LW'(pages))
			&& (LW'(idx) < LW'(STORE_DEPTH));
	end

	logic                  vis_s1;
	logic [AW-1:0]         idx_s1;
	logic [PAGE_SHIFT-1:0] bit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (ctl.load) begin
			addr_q <= '0;
		end else if (ctl.clr_step || ctl.init_step) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			func_q   <= func;
			mode_q   <= pen_mode;
			ridx_q   <= read_index;
			x_q      <= x0e;
			y_q      <= y0e;
			xmaj_q   <= xmaj_n;
			sx_neg_q <= dx[XW-1];
			sy_neg_q <= dy[XW-1];
			dmaj_q   <= xmaj_n ? adx : ady;
			dmin_q   <= xmaj_n ? ady : adx;
			cnt_q    <= xmaj_n ? adx : ady;
			err_q    <= EW'({1'b0, (xmaj_n ? adx : ady) >> 1});
		end else if (ctl.line_wr) begin
			x_q   <= x_n;
			y_q   <= y_n;
			err_q <= err_n;
			cnt_q <= cnt_q - COORD_BITS'(1);
		end
		if (ctl.line_rd) begin
			vis_s1 <= vis;
			idx_s1 <= AW'(idx);
			bit_s1 <= y_q[PAGE_SHIFT-1:0];
		end
	end

	// frame store
	logic [DATA_BITS-1:0] rd_data, new_byte, mask, wr_data;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic                 wr_en, rd_en, clr_en;

	always_comb begin
		mask = DATA_BITS'(1) << bit_s1;
		case (mode_q)
			PEN_SET:    new_byte = rd_data | mask;
			PEN_CLEAR:  new_byte = rd_data & ~mask;
			PEN_INVERT: new_byte = rd_data ^ mask;
			default:    new_byte = rd_data;
		endcase
		clr_en  = (LW'(addr_q) < LW'(n_bytes));
		wr_en   = (ctl.line_wr && vis_s1) || (ctl.clr_step && clr_en) || ctl.init_step;
		wr_addr = ctl.line_wr ? idx_s1 : addr_q;
		wr_data = ctl.line_wr ? new_byte : '0;
		rd_en   = ctl.line_rd || ctl.rd_issue;
		rd_addr = ctl.rd_issue ? AW'(ridx_q) : AW'(idx);
	end

	lfp_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status
	always_comb begin
		sts.init_last = (addr_q == AW'(STORE_DEPTH - 1));
		sts.cnt_zero  = (cnt_q == '0);
		sts.clr_last  = ((LW'(addr_q) + LW'(1)) >= LW'(n_bytes));
	end

	// result
	logic                 rd_err;
	logic [DATA_BITS-1:0] read_data_q;
	logic                 index_error_q;

	assign rd_err = (LW'(ridx_q) >= LW'(n_bytes));

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			read_data_q   <= (func_q == FN_READ && !rd_err) ? rd_data : '0;
			index_error_q <= (func_q == FN_READ) && rd_err;
		end
	end

	assign read_data   = read_data_q;
	assign index_error = index_error_q;

endmodule

// ===== design/line_framebuffer_plotter.sv =====
// ----------------------------------------------------------------------------
// line_framebuffer_plotter
// Monochrome page-layout frame store with Bresenham line draw, clear and
// byte read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to zero, one byte per cycle,
// with cmd_ready low; configuration writes are taken at any time. Every
// command then gives exactly one result. In a line, each pixel is a
// read-modify-write on the single read and single write port of the store,
// read in one cycle and written in the next. A clear writes one byte per
// cycle. A read goes through the registered store output. The result
// register lets a finished result wait for rsp_ready while the next command
// is already being taken.
// ----------------------------------------------------------------------------
module line_framebuffer_plotter #(
	parameter int MAX_WIDTH   = lfp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = lfp_pkg::MAX_HEIGHT_DEF,
	parameter int STORE_DEPTH = lfp_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS  = lfp_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lfp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lfp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic [lfp_pkg::FUNC_BITS-1:0]        func,
	input  logic signed [COORD_BITS-1:0]         x_start,
	input  logic signed [COORD_BITS-1:0]         y_start,
	input  logic signed [COORD_BITS-1:0]         x_end,
	input  logic signed [COORD_BITS-1:0]         y_end,
	input  logic [lfp_pkg::PEN_BITS-1:0]         pen_mode,
	input  logic [lfp_pkg::READ_INDEX_BITS-1:0]  read_index,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [lfp_pkg::DATA_BITS-1:0]        read_data,
	output logic                                 index_error
);
	import lfp_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.func      (func),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	lfp_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.STORE_DEPTH (STORE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.pen_mode    (pen_mode),
		.read_index  (read_index),
		.read_data   (read_data),
		.index_error (index_error)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line plotter: draws, clears and byte reads go
// through the command channel, and a behavioral copy of the page-layout frame
// store predicts each response. Screen size is reprogrammed between phases,
// and both handshakes idle at random, with one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
	import lfp_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int MAX_W   = MAX_WIDTH_DEF;
	localparam int MAX_H   = MAX_HEIGHT_DEF;
	localparam int STORE_D = STORE_DEPTH_DEF;

	localparam logic [FUNC_BITS-1:0] FN_NONE  = 2'd3;
	localparam logic [PEN_BITS-1:0]  PEN_HOLD = 2'd3;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_PRINTS    = 100;
	// worst case per command: a 1024-pixel line, longest gap and the hold-off
	localparam int unsigned LIMIT_CYCLES = 1400 * (2 * 1025 + 2 + HOLD_CYCLES + 60) * 3
		+ 4 * STORE_D;

	typedef struct {
		logic [FUNC_BITS-1:0]       fn;
		logic signed [COORD_W-1:0]  xs;
		logic signed [COORD_W-1:0]  ys;
		logic signed [COORD_W-1:0]  xe;
		logic signed [COORD_W-1:0]  ye;
		logic [PEN_BITS-1:0]        pen;
		logic [READ_INDEX_BITS-1:0] ridx;
	} cmd_t;

	typedef struct {
		logic [DATA_BITS-1:0] data;
		logic                 err;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
	logic                       cmd_valid = 1'b0;
	logic                       cmd_ready;
	logic [FUNC_BITS-1:0]       func = '0;
	logic signed [COORD_W-1:0]  x_start = '0;
	logic signed [COORD_W-1:0]  y_start = '0;
	logic signed [COORD_W-1:0]  x_end = '0;
	logic signed [COORD_W-1:0]  y_end = '0;
	logic [PEN_BITS-1:0]        pen_mode = '0;
	logic [READ_INDEX_BITS-1:0] read_index = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	logic [DATA_BITS-1:0]       read_data;
	logic                       index_error;

	// behavioral frame store and screen registers
	logic [DATA_BITS-1:0]       fb_model [STORE_D];
	logic [WIDTH_REG_BITS-1:0]  model_width = SCREEN_WIDTH_RST;
	logic [HEIGHT_REG_BITS-1:0] model_height = SCREEN_HEIGHT_RST;
	rsp_t                       expected_rsp [$];

	int  errors = 0;
	int  prints = 0;
	int  n_checked = 0;
	int  n_lines = 0;
	int  n_clears = 0;
	int  n_reads = 0;
	int  n_flagged = 0;
	int  n_settings = 0;
	int  hold_rsp = 0;
	bit  gapless = 1'b0;
	int unsigned cycles = 0;

	line_framebuffer_plotter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.func        (func),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.pen_mode    (pen_mode),
		.read_index  (read_index),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.read_data   (read_data),
		.index_error (index_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
				cycles, expected_rsp.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic int eff_width();
		return (int'(model_width) > MAX_W) ? MAX_W : int'(model_width);
	endfunction

	function automatic int eff_height();
		int h;
		h = (int'(model_height) > MAX_H) ? MAX_H : int'(model_height);
		return h & ~(PAGE_ROWS - 1);
	endfunction

	function automatic int store_count();
		int n;
		n = eff_width() * eff_height() / PAGE_ROWS;
		return (n > STORE_D) ? STORE_D : n;
	endfunction

	task automatic paint_pixel(input int px, input int py, input logic [PEN_BITS-1:0] pen);
		int w;
		int h;
		int idx;
		logic [DATA_BITS-1:0] m;
		w = eff_width();
		h = eff_height();
		if (px < 0 || py < 0 || px >= w || py >= h)
			return;
		idx = px + (py >> PAGE_SHIFT) * w;
		if (idx >= STORE_D)
			return;
		m = 8'd1 << (py % PAGE_ROWS);
		case (pen)
			PEN_SET:    fb_model[idx] = fb_model[idx] | m;
			PEN_CLEAR:  fb_model[idx] = fb_model[idx] & ~m;
			PEN_INVERT: fb_model[idx] = fb_model[idx] ^ m;
			default: ;
		endcase
	endtask

	task automatic raster_line(input int x0, input int y0, input int x1, input int y1,
			input logic [PEN_BITS-1:0] pen);
		int dx;
		int dy;
		int sx;
		int sy;
		int x;
		int y;
		int acc;
		int n;
		dx = x1 - x0;
		dy = y1 - y0;
		sx = (dx >= 0) ? 1 : -1;
		sy = (dy >= 0) ? 1 : -1;
		x = x0;
		y = y0;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx >= dy) begin
			acc = dx / 2;
			for (n = 0; n <= dx; n++) begin
				paint_pixel(x, y, pen);
				acc -= dy;
				if (acc < 0) begin
					y += sy;
					acc += dx;
				end
				x += sx;
			end
		end else begin
			acc = dy / 2;
			for (n = 0; n <= dy; n++) begin
				paint_pixel(x, y, pen);
				acc -= dx;
				if (acc < 0) begin
					x += sx;
					acc += dy;
				end
				y += sy;
			end
		end
	endtask

	task automatic apply_and_expect(input cmd_t c);
		rsp_t r;
		int   cnt;
		int   k;
		r.data = '0;
		r.err = 1'b0;
		case (c.fn)
			FN_LINE: begin
				raster_line(int'(c.xs), int'(c.ys), int'(c.xe), int'(c.ye), c.pen);
				n_lines++;
			end
			FN_CLEAR: begin
				cnt = store_count();
				for (k = 0; k < cnt; k++)
					fb_model[k] = '0;
				n_clears++;
			end
			FN_READ: begin
				cnt = store_count();
				if (int'(c.ridx) >= cnt) begin
					r.err = 1'b1;
					n_flagged++;
				end else begin
					r.data = fb_model[c.ridx];
				end
				n_reads++;
			end
			default: ;
		endcase
		expected_rsp.push_back(r);
	endtask

	// ---------------- response check ----------------
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				errors++;
				if (prints < MAX_PRINTS) begin
					prints++;
					$display("%0t: unexpected response: expected none, actual data %02h err %0b",
						$time, read_data, index_error);
				end
			end else begin
				want = expected_rsp.pop_front();
				n_checked++;
				if (read_data !== want.data) begin
					errors++;
					if (prints < MAX_PRINTS) begin
						prints++;
						$display("%0t: read_data mismatch: expected %02h actual %02h",
							$time, want.data, read_data);
					end
				end
				if (index_error !== want.err) begin
					errors++;
					if (prints < MAX_PRINTS) begin
						prints++;
						$display("%0t: index_error mismatch: expected %0b actual %0b",
							$time, want.err, index_error);
					end
				end
			end
		end
	end

	// ---------------- idle patterns ----------------
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int send_gap();
		return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
	endfunction

	initial begin : rsp_side
		int run;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp > 0) begin
				rsp_ready = 1'b0;
				hold_rsp--;
				run = 0;
			end else if (gapless) begin
				rsp_ready = 1'b1;
			end else begin
				if (run == 0) begin
					if ($urandom_range(0, 2) == 0) begin
						rsp_ready = 1'b0;
						run = idle_len();
					end else begin
						rsp_ready = 1'b1;
						run = $urandom_range(1, 24);
					end
				end
				run--;
			end
		end
	end

	// ---------------- command building ----------------
	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.fn = FUNC_BITS'($urandom);
		c.xs = COORD_W'($urandom);
		c.ys = COORD_W'($urandom);
		c.xe = COORD_W'($urandom);
		c.ye = COORD_W'($urandom);
		c.pen = PEN_BITS'($urandom);
		c.ridx = READ_INDEX_BITS'($urandom);
		return c;
	endfunction

	function automatic cmd_t line_cmd(input int x0, input int y0, input int x1, input int y1,
			input logic [PEN_BITS-1:0] pen);
		cmd_t c;
		c = noise_cmd();
		c.fn = FN_LINE;
		c.xs = COORD_W'(x0);
		c.ys = COORD_W'(y0);
		c.xe = COORD_W'(x1);
		c.ye = COORD_W'(y1);
		c.pen = pen;
		return c;
	endfunction

	function automatic cmd_t read_cmd(input int idx);
		cmd_t c;
		c = noise_cmd();
		c.fn = FN_READ;
		c.ridx = READ_INDEX_BITS'(idx);
		return c;
	endfunction

	function automatic cmd_t clear_cmd();
		cmd_t c;
		c = noise_cmd();
		c.fn = FN_CLEAR;
		return c;
	endfunction

	function automatic int near(input int span);
		return int'($urandom_range(0, span + 24)) - 12;
	endfunction

	// mostly on-screen lines and in-range reads, some wild lines, rare clears
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		int   w;
		int   h;
		int   cnt;
		r = $urandom_range(0, 99);
		w = (eff_width() > 0) ? eff_width() : 16;
		h = (eff_height() > 0) ? eff_height() : 16;
		cnt = store_count();
		if (r < 50) begin
			c = line_cmd(near(w), near(h), near(w), near(h), PEN_BITS'($urandom));
		end else if (r < 56) begin
			c = noise_cmd();
			c.fn = FN_LINE;
		end else if (r < 92) begin
			if (cnt > 0 && $urandom_range(0, 99) < 80)
				c = read_cmd($urandom_range(0, cnt - 1));
			else if (cnt < STORE_D && $urandom_range(0, 1) == 0)
				c = read_cmd($urandom_range(cnt, STORE_D - 1));
			else
				c = read_cmd($urandom);
		end else if (r < 97) begin
			c = clear_cmd();
		end else begin
			c = noise_cmd();
			c.fn = FN_NONE;
		end
		return c;
	endfunction

	// ---------------- channel tasks ----------------
	task automatic send_cmd(input cmd_t c);
		int gap;
		cmd_valid = 1'b1;
		func = c.fn;
		x_start = c.xs;
		y_start = c.ys;
		x_end = c.xe;
		y_end = c.ye;
		pen_mode = c.pen;
		read_index = c.ridx;
		do @(posedge clk); while (!cmd_ready);
		apply_and_expect(c);
		@(negedge clk);
		gap = gapless ? 0 : send_gap();
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SCREEN_WIDTH)
			model_width = val;
		else
			model_height = val[HEIGHT_REG_BITS-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_idle();
		cmd_valid = 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_screen(input logic [CFG_DATA_BITS-1:0] w,
			input logic [CFG_DATA_BITS-1:0] h);
		wait_idle();
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		n_settings++;
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		cmd_t c;
		send_cmd(read_cmd(0));
		send_cmd(read_cmd(STORE_D - 1));
		send_cmd(line_cmd(0, 0, 127, 63, PEN_SET));
		send_cmd(read_cmd(0));
		send_cmd(read_cmd(127 + 7 * 128));
		send_cmd(line_cmd(127, 0, 0, 63, PEN_INVERT));
		send_cmd(read_cmd(63 + 3 * 128));
		send_cmd(line_cmd(5, 5, 5, 5, PEN_SET));
		send_cmd(read_cmd(5));
		send_cmd(line_cmd(10, 0, 12, 63, PEN_SET));
		send_cmd(read_cmd(11 + 4 * 128));
		send_cmd(line_cmd(0, 8, 127, 8, PEN_INVERT));
		send_cmd(read_cmd(10 + 128));
		send_cmd(line_cmd(20, 20, 90, 40, PEN_HOLD));
		send_cmd(read_cmd(20 + 2 * 128));
		send_cmd(line_cmd(-512, -512, 511, 511, PEN_INVERT));
		send_cmd(line_cmd(511, -512, -512, 511, PEN_CLEAR));
		send_cmd(line_cmd(30, 60, 30, -5, PEN_CLEAR));
		send_cmd(read_cmd(30 + 5 * 128));
		c = noise_cmd();
		c.fn = FN_NONE;
		send_cmd(c);
		send_cmd(clear_cmd());
		send_cmd(read_cmd(11 + 4 * 128));
		send_cmd(read_cmd(STORE_D - 1));
	endtask

	// narrowest, zero width, short height, saturated, masked and odd sizes
	task automatic test_config_sweep();
		int widths [8]  = '{1, 0, 128, 255, 100, 37, 8, 128};
		int heights [8] = '{8, 64, 5, 127, 200, 37, 24, 64};
		int p;
		for (p = 0; p < 8; p++) begin
			set_screen(CFG_DATA_BITS'(widths[p]), CFG_DATA_BITS'(heights[p]));
			repeat (40) send_cmd(random_cmd());
		end
	endtask

	task automatic test_backpressure();
		int k;
		wait_idle();
		gapless = 1'b1;
		hold_rsp = HOLD_CYCLES;
		for (k = 0; k < 24; k++) begin
			if (k % 2 == 0)
				send_cmd(read_cmd($urandom_range(0, STORE_D - 1)));
			else
				send_cmd(line_cmd(near(8), near(8), near(8), near(8), PEN_INVERT));
		end
		gapless = 1'b0;
	endtask

	task automatic test_random();
		int ws [3] = '{128, 96, 128};
		int hs [3] = '{64, 45, 64};
		int s;
		int i;
		for (s = 0; s < 3; s++) begin
			set_screen(CFG_DATA_BITS'(ws[s]), CFG_DATA_BITS'(hs[s]));
			for (i = 0; i < 300; i++) begin
				gapless = (i % 150) < 25;
				send_cmd(random_cmd());
			end
			gapless = 1'b0;
		end
	endtask

	initial begin : main
		int k;
		for (k = 0; k < STORE_D; k++)
			fb_model[k] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random();
		wait_idle();
		repeat (64) @(negedge clk);
		$display("run covered %0d lines, %0d clears, %0d reads (%0d flagged)",
			n_lines, n_clears, n_reads, n_flagged);
		$display("over %0d screen sizes; %0d responses compared, %0d mismatches",
			n_settings, n_checked, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
